FILE: rtl/clt_pkg.sv
`default_nettype none
package clt_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int CFG_IW    = 1;
  localparam int CFG_DW    = 1;

  localparam logic [CFG_IW-1:0] CFG_ECHO_ENABLE = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_LINE_MODE   = 1'b1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_CTRL_C = 8'h03;
  localparam logic [7:0] CH_CTRL_D = 8'h04;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_CTRL_P = 8'h10;
  localparam logic [7:0] CH_CTRL_S = 8'h13;
  localparam logic [7:0] CH_CTRL_U = 8'h15;
  localparam logic [7:0] CH_CTRL_Z = 8'h1a;
  localparam logic [7:0] CH_DEL    = 8'h7f;

  typedef enum logic [1:0] {
    CMD_CHAR  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_PLIST = 3'd1,
    EV_INTR  = 3'd2,
    EV_STOP  = 3'd3,
    EV_DEBUG = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_KILL
  } state_t;

  // Classification of one received byte
  typedef struct packed {
    event_t     ev;
    logic       kill;
    logic       erase;
    logic       store;
    logic       commits;
    logic [7:0] data;
  } class_t;

  typedef struct packed {
    logic [7:0] rd_data;
    logic       rd_valid;
    logic       rd_eof;
    logic       rd_line_end;
    logic [7:0] echo_char;
    logic       echo_valid;
    logic [7:0] erase_count;
    logic       line_ready;
    event_t     event_res;
    logic       overflow;
  } res_t;

endpackage
`default_nettype wire

FILE: rtl/clt_ram.sv
`default_nettype none
module clt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

FILE: rtl/clt_decode.sv
`default_nettype none
module clt_decode (
  input  wire logic [7:0]      rx_char,
  input  wire logic            line_mode,
  output clt_pkg::class_t      cls
);
  import clt_pkg::*;

  event_t ev;

  always_comb begin
    unique case (rx_char)
      CH_CTRL_P: ev = EV_PLIST;
      CH_CTRL_C: ev = EV_INTR;
      CH_CTRL_Z: ev = EV_STOP;
      CH_CTRL_S: ev = EV_DEBUG;
      default:   ev = EV_NONE;
    endcase
  end

  always_comb begin
    cls    = '0;
    cls.ev = ev;
    if (line_mode) begin
      cls.kill  = (ev == EV_NONE) && (rx_char == CH_CTRL_U);
      cls.erase = (ev == EV_NONE) && ((rx_char == CH_BS) || (rx_char == CH_DEL));
      cls.store = (ev == EV_NONE) && !cls.kill && !cls.erase && (rx_char != CH_NUL);
    end else begin
      // raw: interrupt still stores a zero byte, other events store nothing
      cls.store = (ev == EV_NONE) || (ev == EV_INTR);
    end
    if (ev == EV_INTR) begin
      cls.data = CH_NUL;
    end else if (rx_char == CH_CR) begin
      cls.data = CH_LF;
    end else begin
      cls.data = rx_char;
    end
    cls.commits = !line_mode || (cls.data == CH_LF) || (cls.data == CH_CTRL_D);
  end

endmodule
`default_nettype wire

FILE: rtl/console_line_discipline_core.sv
`default_nettype none
// Channel   Handshake          Payload
// request   start / busy       in_cmd, in_rx_char, in_read_first
// result    out_strobe (1 clk) out_rd_*, out_echo_*, out_erase_count, out_line_ready,
//                              out_event_res, out_overflow
// config    cfg_we             cfg_idx, cfg_wdata
//
// A request is taken when start is high and busy is low; exactly one result follows.
// Character, flush and no-op requests finish in S_EXEC; reads pass on to S_READ when data
// is committed, and a kill-line request with characters to erase passes to S_KILL and
// erases up to DEPTH characters: the backward walk reads one store entry per cycle
// over the single RAM port. A kill-line on an empty line finishes in S_EXEC.
// The result strobe rises in the same cycle as busy falls; a new request may be taken then.
// Reset (rst_n low, synchronous) clears indices, config and control; the character
// store itself needs no clearing. Results cannot be stalled by the receiver.
module console_line_discipline_core #(
  parameter int DEPTH = clt_pkg::DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 in_cmd,
  input  wire logic [7:0]                 in_rx_char,
  input  wire logic                       in_read_first,
  output logic                            out_strobe,
  output logic [7:0]                      out_rd_data,
  output logic                            out_rd_valid,
  output logic                            out_rd_eof,
  output logic                            out_rd_line_end,
  output logic [7:0]                      out_echo_char,
  output logic                            out_echo_valid,
  output logic [7:0]                      out_erase_count,
  output logic                            out_line_ready,
  output logic [2:0]                      out_event_res,
  output logic                            out_overflow,
  input  wire logic                       cfg_we,
  input  wire logic [clt_pkg::CFG_IW-1:0] cfg_idx,
  input  wire logic [clt_pkg::CFG_DW-1:0] cfg_wdata
);
  import clt_pkg::*;

  // An index is {wrap, slot}: it counts modulo 2*DEPTH, slot modulo DEPTH.
  localparam int AW = $clog2(DEPTH);
  localparam int IW = AW + 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = (CW > 8) ? CW : 8;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
    logic [IW-1:0] r;
    if (i[AW-1:0] == AW'(DEPTH - 1)) begin
      r = {~i[AW], {AW{1'b0}}};
    end else begin
      r = {i[AW], i[AW-1:0] + AW'(1)};
    end
    return r;
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i);
    logic [IW-1:0] r;
    if (i[AW-1:0] == '0) begin
      r = {~i[AW], AW'(DEPTH - 1)};
    end else begin
      r = {i[AW], i[AW-1:0] - AW'(1)};
    end
    return r;
  endfunction

  // Ring holds DEPTH entries when slots meet on opposite laps
  function automatic logic idx_full(input logic [IW-1:0] e, input logic [IW-1:0] rd);
    return (e[AW-1:0] == rd[AW-1:0]) && (e[AW] != rd[AW]);
  endfunction

  state_t        state_r, state_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [7:0]    char_r, char_nxt;
  logic          first_r, first_nxt;
  logic [IW-1:0] read_r, read_nxt;
  logic [IW-1:0] commit_r, commit_nxt;
  logic [IW-1:0] edit_r, edit_nxt;
  logic [IW-1:0] look_r, look_nxt;
  logic [KW-1:0] kill_n_r, kill_n_nxt;
  logic          echo_en_r, line_mode_r;
  res_t          res_r, res_nxt;
  logic          strobe_r, strobe_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  class_t        cls;
  logic          accept;
  logic          kill_go;
  logic          read_go;
  logic          kill_done;
  logic          ring_full;
  logic [7:0]    kill_sat;
  logic [IW-1:0] edit_dec;

  clt_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  clt_decode u_decode (
    .rx_char   (char_r),
    .line_mode (line_mode_r),
    .cls       (cls)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign ring_full = idx_full(edit_r, read_r);
  assign edit_dec  = idx_dec(edit_r);
  assign kill_go   = (cmd_r == CMD_CHAR) && line_mode_r && cls.kill && (edit_r != commit_r);
  assign read_go   = (cmd_r == CMD_READ) && (read_r != commit_r);
  // Walk stops at the commit point or just after a newline
  assign kill_done = (edit_r == commit_r) || (mem_rdata == CH_LF);
  assign kill_sat  = (kill_n_r > KW'(255)) ? 8'hff : kill_n_r[7:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        priority if (kill_go) begin
          state_nxt = S_KILL;
        end else if (read_go) begin
          state_nxt = S_READ;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: state_nxt = S_IDLE;
      S_KILL: begin
        if (kill_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, store access and result
  always_comb begin
    cmd_nxt    = cmd_r;
    char_nxt   = char_r;
    first_nxt  = first_r;
    read_nxt   = read_r;
    commit_nxt = commit_r;
    edit_nxt   = edit_r;
    look_nxt   = look_r;
    kill_n_nxt = kill_n_r;
    res_nxt    = '0;
    strobe_nxt = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = edit_r[AW-1:0];
    mem_wdata  = cls.data;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt   = cmd_t'(in_cmd);
          char_nxt  = in_rx_char;
          first_nxt = in_read_first;
        end
      end

      S_EXEC: begin
        strobe_nxt = !(kill_go || read_go);
        unique case (cmd_r)
          CMD_CHAR: begin
            if (line_mode_r) begin
              priority if (cls.ev != EV_NONE) begin
                res_nxt.event_res = cls.ev;
              end else if (cls.kill) begin
                // start the walk: read the entry below edit, look two below
                mem_addr   = edit_dec[AW-1:0];
                look_nxt   = idx_dec(edit_dec);
                kill_n_nxt = '0;
              end else if (cls.erase) begin
                if (edit_r != commit_r) begin
                  edit_nxt = edit_dec;
                  res_nxt.erase_count = {7'd0, echo_en_r};
                end
              end else if (cls.store && !ring_full) begin
                mem_we   = 1'b1;
                edit_nxt = idx_inc(edit_r);
                if (echo_en_r) begin
                  res_nxt.echo_char  = cls.data;
                  res_nxt.echo_valid = 1'b1;
                end
                if (cls.commits || idx_full(idx_inc(edit_r), read_r)) begin
                  commit_nxt         = idx_inc(edit_r);
                  res_nxt.line_ready = 1'b1;
                end
              end
            end else begin
              res_nxt.event_res = cls.ev;
              if (cls.store) begin
                if (!ring_full) begin
                  mem_we             = 1'b1;
                  edit_nxt           = idx_inc(edit_r);
                  commit_nxt         = idx_inc(edit_r);
                  res_nxt.line_ready = 1'b1;
                end else begin
                  res_nxt.overflow = 1'b1;
                end
              end
            end
          end
          CMD_READ: begin
            mem_addr = read_r[AW-1:0];
          end
          CMD_FLUSH: begin
            read_nxt   = '0;
            commit_nxt = '0;
            edit_nxt   = '0;
          end
          CMD_NOP: begin
          end
          default: begin
          end
        endcase
      end

      S_READ: begin
        strobe_nxt = 1'b1;
        if (mem_rdata == CH_CTRL_D) begin
          // end of file: consume the Ctrl-D only on the first byte of a read
          res_nxt.rd_eof = 1'b1;
          if (first_r) begin
            read_nxt = idx_inc(read_r);
          end
        end else begin
          res_nxt.rd_data     = mem_rdata;
          res_nxt.rd_valid    = 1'b1;
          res_nxt.rd_line_end = (mem_rdata == CH_LF);
          read_nxt            = idx_inc(read_r);
        end
      end

      S_KILL: begin
        if (kill_done) begin
          strobe_nxt = 1'b1;
          res_nxt.erase_count = echo_en_r ? kill_sat : 8'd0;
        end else begin
          // drop one character, prefetch the next one down
          edit_nxt   = edit_dec;
          kill_n_nxt = kill_n_r + KW'(1);
          mem_addr   = look_r[AW-1:0];
          look_nxt   = idx_dec(look_r);
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      read_r      <= '0;
      commit_r    <= '0;
      edit_r      <= '0;
      strobe_r    <= 1'b0;
      echo_en_r   <= 1'b1;
      line_mode_r <= 1'b1;
    end else begin
      state_r  <= state_nxt;
      read_r   <= read_nxt;
      commit_r <= commit_nxt;
      edit_r   <= edit_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_ECHO_ENABLE: echo_en_r   <= cfg_wdata[0];
          CFG_LINE_MODE:   line_mode_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    char_r   <= char_nxt;
    first_r  <= first_nxt;
    look_r   <= look_nxt;
    kill_n_r <= kill_n_nxt;
    res_r    <= res_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_rd_data     = res_r.rd_data;
  assign out_rd_valid    = res_r.rd_valid;
  assign out_rd_eof      = res_r.rd_eof;
  assign out_rd_line_end = res_r.rd_line_end;
  assign out_echo_char   = res_r.echo_char;
  assign out_echo_valid  = res_r.echo_valid;
  assign out_erase_count = res_r.erase_count;
  assign out_line_ready  = res_r.line_ready;
  assign out_event_res   = res_r.event_res;
  assign out_overflow    = res_r.overflow;

`ifndef SYNTHESIS
  // A result only follows a cycle of work on a request
  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a request in progress");

  // Slots stay inside the ring for any depth
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (edit_r[AW-1:0] <= AW'(DEPTH - 1)) && (read_r[AW-1:0] <= AW'(DEPTH - 1)))
    else $error("ring slot out of range");

  // A store read for a read request happens only with committed data pending
  a_read_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> $past(read_r != commit_r))
    else $error("read issued on empty committed input");

  // Kill walk never takes edit below commit
  a_kill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_KILL) && (edit_r == commit_r)) |=> (state_r == S_IDLE))
    else $error("kill walk passed the commit point");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/console_line_discipline_core_test.sv
`timescale 1ns / 1ps
module console_line_discipline_core_test;
  import clt_pkg::*;

  localparam int RING = DEPTH_DEF;
  localparam int WRAP = 2 * RING;   // positions run modulo twice the ring size

  // Per-phase register plans, bit p belongs to random phase p
  localparam bit [5:0] ECHO_PLAN = 6'b010101;
  localparam bit [5:0] LINE_PLAN = 6'b010011;

  // One row of the directed table. A register row carries the register index
  // in ch and the value in first.
  typedef struct packed {
    logic       cfg_write;
    logic       pinned;
    cmd_t       cmd;
    logic [7:0] ch;
    logic       first;
    res_t       want;
  } stim_row_t;

  logic                clk;
  logic                rst_n         = 1'b0;
  logic                start         = 1'b0;
  logic                busy;
  logic [1:0]          in_cmd        = CMD_NOP;
  logic [7:0]          in_rx_char    = 8'h00;
  logic                in_read_first = 1'b0;
  logic                out_strobe;
  logic [7:0]          out_rd_data;
  logic                out_rd_valid;
  logic                out_rd_eof;
  logic                out_rd_line_end;
  logic [7:0]          out_echo_char;
  logic                out_echo_valid;
  logic [7:0]          out_erase_count;
  logic                out_line_ready;
  logic [2:0]          out_event_res;
  logic                out_overflow;
  logic                cfg_we        = 1'b0;
  logic [CFG_IW-1:0]   cfg_idx       = '0;
  logic [CFG_DW-1:0]   cfg_wdata     = '0;

  // Typed-in expectation travelling with the request being presented
  logic                pin_on        = 1'b0;
  res_t                pin_res       = '0;

  // Shadow of the line discipline: ring contents, three positions, registers
  logic [7:0]          line_buf [RING];
  int                  rd_pos;
  int                  commit_pos;
  int                  edit_pos;
  logic                echo_on;
  logic                line_on;

  res_t                replies_due [$];
  stim_row_t           directed_rows [$];
  int                  fail_count    = 0;
  int                  req_count     = 0;
  int                  gap_pct       = 0;

  console_line_discipline_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_rx_char      (in_rx_char),
    .in_read_first   (in_read_first),
    .out_strobe      (out_strobe),
    .out_rd_data     (out_rd_data),
    .out_rd_valid    (out_rd_valid),
    .out_rd_eof      (out_rd_eof),
    .out_rd_line_end (out_rd_line_end),
    .out_echo_char   (out_echo_char),
    .out_echo_valid  (out_echo_valid),
    .out_erase_count (out_erase_count),
    .out_line_ready  (out_line_ready),
    .out_event_res   (out_event_res),
    .out_overflow    (out_overflow),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop well past the slowest legal run: every request a full kill-line
  // walk plus long sender gaps.
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Line discipline predictor
  // ---------------------------------------------------------------------------
  function automatic int ring_next(int p);
    return (p + 1) % WRAP;
  endfunction

  function automatic int ring_prev(int p);
    return (p + WRAP - 1) % WRAP;
  endfunction

  function automatic int ring_used();
    return (edit_pos + WRAP - rd_pos) % WRAP;
  endfunction

  function automatic event_t event_for(logic [7:0] c);
    case (c)
      CH_CTRL_P: return EV_PLIST;
      CH_CTRL_C: return EV_INTR;
      CH_CTRL_Z: return EV_STOP;
      CH_CTRL_S: return EV_DEBUG;
      default:   return EV_NONE;
    endcase
  endfunction

  // Apply one request to the shadow state and return the reply it causes.
  function automatic res_t console_step(cmd_t cmd, logic [7:0] ch, logic first);
    res_t   r;
    event_t ev;
    logic [7:0] c;
    int     n;
    r  = '0;
    c  = ch;
    n  = 0;
    ev = event_for(ch);
    case (cmd)
      CMD_CHAR: begin
        if (line_on) begin
          if (ev != EV_NONE) begin
            // Control events edit nothing and report no erase count
            r.event_res = ev;
          end else begin
            if (c == CH_CTRL_U) begin
              // Walk back to the last commit point or a stored newline
              while (edit_pos != commit_pos &&
                     line_buf[ring_prev(edit_pos) % RING] != CH_LF) begin
                edit_pos = ring_prev(edit_pos);
                n++;
              end
            end else if (c == CH_BS || c == CH_DEL) begin
              if (edit_pos != commit_pos) begin
                edit_pos = ring_prev(edit_pos);
                n = 1;
              end
            end else if (c != CH_NUL && ring_used() < RING) begin
              if (c == CH_CR) c = CH_LF;
              line_buf[edit_pos % RING] = c;
              edit_pos = ring_next(edit_pos);
              if (echo_on) begin
                r.echo_char  = c;
                r.echo_valid = 1'b1;
              end
              // Newline, end of file or a full ring hands the line to readers
              if (c == CH_LF || c == CH_CTRL_D || ring_used() == RING) begin
                commit_pos   = edit_pos;
                r.line_ready = 1'b1;
              end
            end
            if (echo_on) r.erase_count = (n > 255) ? 8'd255 : 8'(n);
          end
        end else begin
          r.event_res = ev;
          if (ev == EV_NONE || ev == EV_INTR) begin
            // Raw interrupt still delivers a zero byte
            if (ev == EV_INTR) c = CH_NUL;
            else if (c == CH_CR) c = CH_LF;
            if (ring_used() < RING) begin
              line_buf[edit_pos % RING] = c;
              edit_pos     = ring_next(edit_pos);
              commit_pos   = edit_pos;
              r.line_ready = 1'b1;
            end else begin
              r.overflow = 1'b1;
            end
          end
        end
      end
      CMD_READ: begin
        if (rd_pos != commit_pos) begin
          c = line_buf[rd_pos % RING];
          if (c == CH_CTRL_D) begin
            // End of file is consumed only by the first byte of a read
            r.rd_eof = 1'b1;
            if (first) rd_pos = ring_next(rd_pos);
          end else begin
            r.rd_data     = c;
            r.rd_valid    = 1'b1;
            r.rd_line_end = (c == CH_LF);
            rd_pos        = ring_next(rd_pos);
          end
        end
      end
      CMD_FLUSH: begin
        rd_pos     = 0;
        commit_pos = 0;
        edit_pos   = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Reply checking and request capture, all on the rising edge
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    res_t due;
    if (!rst_n) begin
      rd_pos     = 0;
      commit_pos = 0;
      edit_pos   = 0;
      echo_on    = 1'b1;
      line_on    = 1'b1;
    end else begin
      // Compare the strobed reply with the oldest outstanding request
      if (out_strobe) begin
        if (replies_due.size() == 0) begin
          $error("reply strobed with no request outstanding");
          fail_count++;
        end else begin
          due = replies_due.pop_front();
          check_field("rd_data",     due.rd_data,     out_rd_data);
          check_field("rd_valid",    due.rd_valid,    out_rd_valid);
          check_field("rd_eof",      due.rd_eof,      out_rd_eof);
          check_field("rd_line_end", due.rd_line_end, out_rd_line_end);
          check_field("echo_char",   due.echo_char,   out_echo_char);
          check_field("echo_valid",  due.echo_valid,  out_echo_valid);
          check_field("erase_count", due.erase_count, out_erase_count);
          check_field("line_ready",  due.line_ready,  out_line_ready);
          check_field("event_res",   due.event_res,   out_event_res);
          check_field("overflow",    due.overflow,    out_overflow);
        end
      end
      // Mirror register writes into the shadow
      if (cfg_we) begin
        case (cfg_idx)
          CFG_ECHO_ENABLE: echo_on = cfg_wdata[0];
          CFG_LINE_MODE:   line_on = cfg_wdata[0];
          default: ;
        endcase
      end
      // Step the shadow on every accepted request; a typed-in row overrides
      // the predicted reply but the shadow still advances.
      if (start && !busy) begin
        due = console_step(cmd_t'(in_cmd), in_rx_char, in_read_first);
        replies_due.push_back(pin_on ? pin_res : due);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driving, all on the falling edge
  // ---------------------------------------------------------------------------
  task automatic send(input cmd_t cmd, input logic [7:0] ch, input logic first,
                      input logic pinned, input res_t want);
    // Idle the request line for a random number of cycles first
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start         <= 1'b1;
    in_cmd        <= cmd;
    in_rx_char    <= ch;
    in_read_first <= first;
    pin_on        <= pinned;
    pin_res       <= want;
    // Hold until the block takes the request
    do @(posedge clk); while (busy);
    req_count++;
    @(negedge clk);
  endtask

  task automatic key(input logic [7:0] ch);
    send(CMD_CHAR, ch, 1'b0, 1'b0, '0);
  endtask

  task automatic pop_byte(input logic first);
    send(CMD_READ, 8'($urandom_range(0, 255)), first, 1'b0, '0);
  endtask

  // Drop start and wait for every outstanding reply; the block is idle then
  task automatic settle();
    start <= 1'b0;
    while (replies_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Random sessions
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] body_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4)  return CH_BS;
    if (pick < 8)  return CH_DEL;
    if (pick < 11) return CH_CTRL_U;
    if (pick < 15) begin
      case ($urandom_range(0, 3))
        0:       return CH_CTRL_P;
        1:       return CH_CTRL_C;
        2:       return CH_CTRL_Z;
        default: return CH_CTRL_S;
      endcase
    end
    if (pick < 20) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h20, 8'h7e));
  endfunction

  // Type one line with some editing, usually terminate it, then read part or all back.
  // A few lines run past the ring size to hit the full-ring cases.
  task automatic type_line();
    int len;
    int pick;
    int reads;
    pick = $urandom_range(0, 99);
    if (pick < 85)      len = $urandom_range(1, 12);
    else if (pick < 95) len = $urandom_range(20, 60);
    else                len = $urandom_range(RING - 8, RING + 12);
    for (int i = 0; i < len; i++) key(body_char());
    pick = $urandom_range(0, 99);
    if (pick < 45)      key(CH_LF);
    else if (pick < 75) key(CH_CR);
    else if (pick < 90) key(CH_CTRL_D);
    reads = $urandom_range(0, len + 3);
    for (int i = 0; i < reads; i++) pop_byte(i == 0 || $urandom_range(0, 9) == 0);
  endtask

  task automatic run_phase(input int items);
    int base;
    int pick;
    base = req_count;
    while (req_count - base < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        type_line();
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 6)) pop_byte(1'($urandom_range(0, 1)));
      end else if (pick < 95) begin
        // Noise: any command, any byte, any first flag
        send(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)), 1'b0, '0);
      end else begin
        send(CMD_FLUSH, 8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table helpers
  // ---------------------------------------------------------------------------
  function automatic res_t echoed(logic [7:0] c, logic ready);
    res_t r;
    r            = '0;
    r.echo_char  = c;
    r.echo_valid = 1'b1;
    r.line_ready = ready;
    return r;
  endfunction

  function automatic res_t erased(logic [7:0] n);
    res_t r;
    r             = '0;
    r.erase_count = n;
    return r;
  endfunction

  function automatic res_t raised(event_t ev);
    res_t r;
    r           = '0;
    r.event_res = ev;
    return r;
  endfunction

  function automatic res_t raw_taken(event_t ev);
    res_t r;
    r            = '0;
    r.event_res  = ev;
    r.line_ready = 1'b1;
    return r;
  endfunction

  function automatic res_t eof_hit();
    res_t r;
    r        = '0;
    r.rd_eof = 1'b1;
    return r;
  endfunction

  function automatic void add_row(cmd_t cmd, logic [7:0] ch, logic first,
                                  logic pinned, res_t want);
    stim_row_t r;
    r.cfg_write = 1'b0;
    r.pinned    = pinned;
    r.cmd       = cmd;
    r.ch        = ch;
    r.first     = first;
    r.want      = want;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic [CFG_IW-1:0] idx, logic val);
    stim_row_t r;
    r           = '0;
    r.cfg_write = 1'b1;
    r.cmd       = CMD_NOP;
    r.ch        = 8'(idx);
    r.first     = val;
    directed_rows.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t r;

    // Directed table, starting from reset: echo on, line mode
    add_row(CMD_READ, CH_NUL,    1'b1, 1'b1, '0);                 // read with nothing committed
    add_row(CMD_CHAR, 8'h61,     1'b0, 1'b1, echoed(8'h61, 1'b0)); // 'a'
    add_row(CMD_CHAR, CH_BS,     1'b0, 1'b1, erased(8'd1));
    add_row(CMD_CHAR, CH_BS,     1'b0, 1'b1, '0);                 // backspace on empty line
    add_row(CMD_CHAR, CH_NUL,    1'b0, 1'b1, '0);                 // zero byte ignored
    add_row(CMD_CHAR, 8'hff,     1'b0, 1'b1, echoed(8'hff, 1'b0));
    add_row(CMD_CHAR, CH_DEL,    1'b0, 1'b1, erased(8'd1));
    add_row(CMD_CHAR, 8'h63,     1'b0, 1'b0, '0);                 // 'c'
    add_row(CMD_CHAR, CH_CTRL_U, 1'b0, 1'b0, '0);                 // kill line
    add_row(CMD_CHAR, CH_CTRL_P, 1'b0, 1'b1, raised(EV_PLIST));
    add_row(CMD_CHAR, CH_CTRL_C, 1'b0, 1'b1, raised(EV_INTR));
    add_row(CMD_CHAR, CH_CTRL_Z, 1'b0, 1'b1, raised(EV_STOP));
    add_row(CMD_CHAR, CH_CTRL_S, 1'b0, 1'b1, raised(EV_DEBUG));
    add_row(CMD_CHAR, 8'h78,     1'b0, 1'b0, '0);                 // 'x'
    add_row(CMD_CHAR, CH_CR,     1'b0, 1'b1, echoed(CH_LF, 1'b1)); // CR becomes LF, commits
    add_row(CMD_READ, CH_NUL,    1'b1, 1'b0, '0);
    add_row(CMD_READ, CH_NUL,    1'b0, 1'b0, '0);                 // newline ends the read
    add_row(CMD_CHAR, CH_CTRL_D, 1'b0, 1'b1, echoed(CH_CTRL_D, 1'b1));
    add_row(CMD_READ, CH_NUL,    1'b0, 1'b1, eof_hit());          // later byte: Ctrl-D stays
    add_row(CMD_READ, CH_NUL,    1'b1, 1'b1, eof_hit());          // first byte: Ctrl-D consumed
    add_row(CMD_NOP,  8'hff,     1'b1, 1'b1, '0);
    add_cfg(CFG_LINE_MODE, 1'b0);
    add_row(CMD_CHAR, CH_CTRL_C, 1'b0, 1'b1, raw_taken(EV_INTR)); // raw interrupt stores zero
    add_row(CMD_CHAR, CH_CTRL_S, 1'b0, 1'b1, raised(EV_DEBUG));   // raw event only
    add_row(CMD_CHAR, CH_DEL,    1'b0, 1'b1, raw_taken(EV_NONE)); // raw DEL is a plain byte
    add_row(CMD_READ, CH_NUL,    1'b1, 1'b0, '0);
    add_row(CMD_FLUSH, 8'h00,    1'b0, 1'b1, '0);

    // Hold reset, release on a falling edge
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table
    gap_pct = 30;
    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.cfg_write) begin
        settle();
        write_reg(r.ch[CFG_IW-1:0], r.first);
      end else begin
        send(r.cmd, r.ch, r.first, r.pinned, r.want);
      end
    end

    // Random phases: sender gaps 30%, then 59%, then none, each under two
    // register settings so that all four combinations come up. A phase may
    // run past its count by the tail of its last line.
    for (int p = 0; p < 6; p++) begin
      settle();
      write_reg(CFG_ECHO_ENABLE, ECHO_PLAN[p]);
      write_reg(CFG_LINE_MODE, LINE_PLAN[p]);
      gap_pct = (p < 2) ? 30 : (p < 4) ? 59 : 0;
      run_phase(75);
    end

    // Drain, then give a stray reply time to show up
    settle();
    repeat (RING + 8) @(posedge clk);
    if (replies_due.size() != 0) $error("%0d replies never arrived", replies_due.size());
    if (fail_count == 0 && replies_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/clt_pkg.sv
rtl/clt_ram.sv
rtl/clt_decode.sv
rtl/console_line_discipline_core.sv
tb/sv/console_line_discipline_core_test.sv
